// ----- design/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg: shared types and codes of the positional list engine
// Command and status codes, field widths and stream word sizes.
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int OP_W     = 3;
   localparam int POS_W    = 5;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int ECNT_W   = 5;

   // req tdata: op, position, word_in -> 40 bits, whole bytes
   localparam int REQ_TDATA_W = 40;
   // rsp tdata: status, entry_count, word_out -> 39 bits, padded to 40
   localparam int RSP_TDATA_W = 40;

   typedef logic [OP_W-1:0]     op_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam op_type OP_APPEND   = 3'd0;
   localparam op_type OP_INSERT   = 3'd1;
   localparam op_type OP_DEL_POS  = 3'd2;
   localparam op_type OP_DEL_LAST = 3'd3;
   localparam op_type OP_DUMP     = 3'd4;

   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_FULL   = 2'd1;
   localparam status_type ST_BADPOS = 2'd2;
   localparam status_type ST_EMPTY  = 2'd3;

endpackage

// ----- design/ple_entry_ram.sv -----
// ----------------------------------------------------------------------------
// ple_entry_ram: list entry storage
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ple_entry_ram #(
   parameter int DEPTH = 16
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  logic [ple_pkg::WORD_W-1:0]    wr_data,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output logic [ple_pkg::WORD_W-1:0]    rd_data
);
   import ple_pkg::*;

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/positional_list_engine_unit.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine_unit: ordered list of signed words
// Append, positional insert/delete, delete last and dump over a small RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one command per transfer (op, position, word_in).
//   rsp channel returns results; a dump of a non-empty list gives one
//   result per entry with tlast on the final one, every other command
//   gives one result with tlast set.
//   req_tready is high only while the sequencer is idle; one command is
//   worked on at a time.
// Steps per command (c = count, p = position):
//   append, delete last, refused or unused op: handled on acceptance.
//   insert: entries p..c move up one at a time, each read and then
//   written through the RAM read/write port; then the word goes to p.
//   delete at position: entries p+1..c move down one at a time, each
//   read and then written. dump: each entry is read from RAM, then output.
// Results sit in an output register; a stalled receiver holds the
// sequencer in its result state, and the next command may be taken while
// the final result of the previous one still waits.
// Reset clears the count and the output valid; entry storage is not cleared.
// ----------------------------------------------------------------------------
module positional_list_engine_unit #(
   parameter int DEPTH = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [2:0] op, [7:3] position, [39:8] word_in
   input  logic [ple_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [1:0] status, [6:2] entry_count, [38:7] word_out, [39] zero
   output logic [ple_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   output logic                              rsp_tlast
);
   import ple_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int AW = $clog2(DEPTH);
   localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

   typedef enum logic [8:0] {
      S_IDLE    = 9'b000000001,
      S_SH_RD   = 9'b000000010,
      S_SH_WR   = 9'b000000100,
      S_INS_PUT = 9'b000001000,
      S_DL_RD   = 9'b000010000,
      S_DL_WR   = 9'b000100000,
      S_DP_RD   = 9'b001000000,
      S_DP_OUT  = 9'b010000000,
      S_RESP    = 9'b100000000
   } state_type;

   state_type         state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     idx_ff, idx_in;
   logic [CW-1:0]     pos_ff, pos_in;
   logic [WORD_W-1:0] wrd_ff, wrd_in;
   status_type        st_ff, st_in;

   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff;
   logic [ECNT_W-1:0] rsp_count_ff;
   logic [WORD_W-1:0] rsp_word_ff;
   logic              rsp_last_ff;

   op_type            req_op;
   logic [POS_W-1:0]  req_pos;
   logic [WORD_W-1:0] req_word;
   logic              req_fire;
   logic [XW-1:0]     cnt_x, pos_x;
   logic              full, empty;
   logic [CW-1:0]     idx_m1, idx_p1, pos_m1;

   logic              mem_we;
   logic [AW-1:0]     mem_waddr, mem_raddr;
   logic [WORD_W-1:0] mem_wdata, mem_rdata;

   logic              out_free, out_load, out_last;
   status_type        out_status;
   logic [WORD_W-1:0] out_word;

   assign req_op   = req_tdata[2:0];
   assign req_pos  = req_tdata[7:3];
   assign req_word = req_tdata[39:8];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign cnt_x  = XW'(count_ff);
   assign pos_x  = XW'(req_pos);
   assign full   = (cnt_x >= XW'(DEPTH));
   assign empty  = (count_ff == '0);
   assign idx_m1 = idx_ff - CW'(1);
   assign idx_p1 = idx_ff + CW'(1);
   assign pos_m1 = pos_ff - CW'(1);

   assign out_free = !rsp_valid_ff || rsp_tready;

   ple_entry_ram #(
      .DEPTH(DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      pos_in     = pos_ff;
      wrd_in     = wrd_ff;
      st_in      = st_ff;
      mem_we     = 1'b0;
      mem_waddr  = idx_ff[AW-1:0];
      mem_wdata  = mem_rdata;
      mem_raddr  = idx_ff[AW-1:0];
      out_load   = 1'b0;
      out_status = st_ff;
      out_word   = '0;
      out_last   = 1'b1;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               wrd_in   = req_word;
               pos_in   = CW'(pos_x);
               st_in    = ST_OK;
               state_in = S_RESP;
               unique case (req_op)
                  OP_APPEND: begin
                     if (full) begin
                        st_in = ST_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        mem_waddr = count_ff[AW-1:0];
                        mem_wdata = req_word;
                        count_in  = count_ff + CW'(1);
                     end
                  end
                  OP_INSERT: begin
                     if (full) begin
                        st_in = ST_FULL;
                     end else if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
                        st_in = ST_BADPOS;
                     end else if (pos_x <= cnt_x) begin
                        idx_in   = count_ff;
                        state_in = S_SH_RD;
                     end else begin
                        state_in = S_INS_PUT;
                     end
                  end
                  OP_DEL_POS: begin
                     if (empty) begin
                        st_in = ST_EMPTY;
                     end else if (pos_x == '0 || pos_x > cnt_x) begin
                        st_in = ST_BADPOS;
                     end else if (pos_x < cnt_x) begin
                        idx_in   = CW'(pos_x);
                        state_in = S_DL_RD;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  OP_DEL_LAST: begin
                     if (empty) begin
                        st_in = ST_EMPTY;
                     end else begin
                        count_in = count_ff - CW'(1);
                     end
                  end
                  OP_DUMP: begin
                     if (empty) begin
                        st_in = ST_EMPTY;
                     end else begin
                        idx_in   = '0;
                        state_in = S_DP_RD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SH_RD: begin
            mem_raddr = idx_m1[AW-1:0];
            state_in  = S_SH_WR;
         end
         S_SH_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[AW-1:0];
            mem_wdata = mem_rdata;
            if (idx_ff == pos_ff) begin
               state_in = S_INS_PUT;
            end else begin
               idx_in   = idx_m1;
               state_in = S_SH_RD;
            end
         end
         S_INS_PUT: begin
            mem_we    = 1'b1;
            mem_waddr = pos_m1[AW-1:0];
            mem_wdata = wrd_ff;
            count_in  = count_ff + CW'(1);
            state_in  = S_RESP;
         end
         S_DL_RD: begin
            state_in = S_DL_WR;
         end
         S_DL_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_m1[AW-1:0];
            mem_wdata = mem_rdata;
            if (idx_p1 == count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = S_RESP;
            end else begin
               idx_in   = idx_p1;
               state_in = S_DL_RD;
            end
         end
         S_DP_RD: begin
            state_in = S_DP_OUT;
         end
         S_DP_OUT: begin
            if (out_free) begin
               out_load   = 1'b1;
               out_status = ST_OK;
               out_word   = mem_rdata;
               out_last   = (idx_p1 == count_ff);
               if (idx_p1 == count_ff) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in   = idx_p1;
                  state_in = S_DP_RD;
               end
            end
         end
         S_RESP: begin
            if (out_free) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pos_ff <= pos_in;
      wrd_ff <= wrd_in;
      st_ff  <= st_in;
      if (out_load) begin
         rsp_status_ff <= out_status;
         rsp_count_ff  <= cnt_x[ECNT_W-1:0];
         rsp_word_ff   <= out_word;
         rsp_last_ff   <= out_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_word_ff, rsp_count_ff, rsp_status_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- design/ple_checker.sv -----
// ----------------------------------------------------------------------------
// ple_checker: port-level checks of the positional list engine
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module ple_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [ple_pkg::RSP_TDATA_W-1:0]   rsp_tdata,
   input logic                              rsp_tlast
);
   import ple_pkg::*;

   // stalled result transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp valid after reset");

   // mid-dump result: ok, non-empty, and no command taken meanwhile
   a_dump_mid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |->
         rsp_tdata[1:0] == ST_OK && rsp_tdata[6:2] != '0 && !req_tready)
      else $error("bad mid-dump result");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] == ST_EMPTY |-> rsp_tdata[6:2] == '0 && rsp_tlast)
      else $error("empty status with entries");

   a_word_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != ST_OK |-> rsp_tdata[38:7] == '0)
      else $error("word on refused command");

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (
   .clock     (clock),
   .reset     (reset),
   .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid),
   .rsp_tready(rsp_tready),
   .rsp_tdata (rsp_tdata),
   .rsp_tlast (rsp_tlast)
);
